### sv/mvsm_pkg.sv
`default_nettype none
package mvsm_pkg;

    localparam int VOICES_DEF       = 8;
    localparam int SAMPLE_DEPTH_DEF = 4096;

    localparam int IN_DATA_W  = 112;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 80;

    localparam logic signed [15:0] PCM_MAX  = 16'sh7FFF;
    localparam logic signed [15:0] PCM_MIN  = 16'sh8000;
    localparam logic [9:0]         UNITY_Q8 = 10'd256;

    localparam logic [2:0] REQ_WRITE  = 3'd0;
    localparam logic [2:0] REQ_PLAY   = 3'd1;
    localparam logic [2:0] REQ_STOP   = 3'd2;
    localparam logic [2:0] REQ_PAUSE  = 3'd3;
    localparam logic [2:0] REQ_RENDER = 3'd4;

    localparam logic [4:0] CLIP_SAT  = 5'd31;
    localparam logic [3:0] COUNT_SAT = 4'd15;

    typedef struct packed {
        logic               active;
        logic               paused;
        logic               looping;
        logic [31:0]        ident;
        logic [8:0]         gain;
        logic signed [9:0]  pan;
        logic [11:0]        base;
        logic [12:0]        length;
        logic [12:0]        position;
    } voice_t;

    // one mix term leaving the head of the voice ring
    typedef struct packed {
        logic       valid;
        logic [8:0] lgain;
        logic [8:0] rgain;
    } term_t;

endpackage
`default_nettype wire

### sv/mvsm_ram.sv
`default_nettype none
module mvsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### sv/mvsm_cell.sv
`default_nettype none
module mvsm_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            shift,
    input  wire mvsm_pkg::voice_t din,
    output mvsm_pkg::voice_t     dout
);
    import mvsm_pkg::*;

    voice_t voice_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voice_reg <= '0;
        end
        else if (shift)
        begin
            voice_reg <= din;
        end
    end

    assign dout = voice_reg;
endmodule
`default_nettype wire

### sv/mvsm_mix.sv
`default_nettype none
module mvsm_mix (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           clear,
    input  wire mvsm_pkg::term_t term,
    input  wire logic [31:0]    sample,
    output logic signed [15:0]  acc_left,
    output logic signed [15:0]  acc_right,
    output logic [4:0]          clips
);
    import mvsm_pkg::*;

    logic               prod_valid_reg;
    logic signed [25:0] prod_l_reg, prod_r_reg;
    logic signed [15:0] acc_l_reg, acc_l_next, acc_r_reg, acc_r_next;
    logic [4:0]         clip_reg, clip_next;
    logic [1:0]         clip_inc_l, clip_inc_r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= term.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_l_reg <= $signed(sample[15:0])  * $signed({1'b0, term.lgain});
        prod_r_reg <= $signed(sample[31:16]) * $signed({1'b0, term.rgain});
    end

    // divide by 256 rounding toward zero, then add and clamp
    function automatic logic signed [15:0] add_clamp(
        input logic signed [15:0] acc,
        input logic signed [25:0] prod,
        output logic              clipped
    );
        logic signed [17:0] q;
        logic signed [17:0] s;
        begin
            q = prod[25:8];
            if (prod[25] && (prod[7:0] != 8'd0))
            begin
                q = q + 18'sd1;
            end
            s = 18'(acc) + q;
            clipped = 1'b1;
            if (s > 18'(PCM_MAX))
            begin
                add_clamp = PCM_MAX;
            end
            else if (s < 18'(PCM_MIN))
            begin
                add_clamp = PCM_MIN;
            end
            else
            begin
                add_clamp = s[15:0];
                clipped = 1'b0;
            end
        end
    endfunction

    logic cl_l, cl_r;
    logic [5:0] clip_sum;

    always_comb
    begin
        acc_l_next = add_clamp(acc_l_reg, prod_l_reg, cl_l);
        acc_r_next = add_clamp(acc_r_reg, prod_r_reg, cl_r);
        clip_inc_l = {1'b0, cl_l};
        clip_inc_r = {1'b0, cl_r};
        clip_sum   = 6'(clip_reg) + 6'(clip_inc_l) + 6'(clip_inc_r);
        clip_next  = (clip_sum > 6'(CLIP_SAT)) ? CLIP_SAT : clip_sum[4:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_l_reg <= '0;
            acc_r_reg <= '0;
            clip_reg  <= '0;
        end
        else if (clear)
        begin
            acc_l_reg <= '0;
            acc_r_reg <= '0;
            clip_reg  <= '0;
        end
        else if (prod_valid_reg)
        begin
            acc_l_reg <= acc_l_next;
            acc_r_reg <= acc_r_next;
            clip_reg  <= clip_next;
        end
    end

    assign acc_left  = acc_l_reg;
    assign acc_right = acc_r_reg;
    assign clips     = clip_reg;
endmodule
`default_nettype wire

### sv/multi_voice_sample_mixer.sv
`default_nettype none
// Stereo sample-playback mixer. A sample write goes from the taken request
// straight to the done state and the output register. Play, stop, pause and
// render pass through the ring state, then the drain state, then the done
// state. The voice table is a ring of cells that rotates once per play, stop,
// pause or render request, with one voice reaching the head per cycle. The
// drain covers the RAM read and the gain multipliers; the output register is
// then loaded once it is free. One request is in work at a time. A finished
// result waits in the output register while the next request is taken. A
// second result that is not taken holds the block and its input.
// SAMPLE_DEPTH must be a power of two; addresses wrap modulo it.
module multi_voice_sample_mixer #(
    parameter int VOICES       = mvsm_pkg::VOICES_DEF,
    parameter int SAMPLE_DEPTH = mvsm_pkg::SAMPLE_DEPTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // sample_addr, sample_left, sample_right, frame_count, loop_flag,
    // gain_q8, pan_q8, voice_id, pause_flag
    input  wire logic [mvsm_pkg::IN_DATA_W-1:0]   s_tdata,
    // req_type
    input  wire logic [mvsm_pkg::IN_USER_W-1:0]   s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // status_ok, assigned_id, mix_left, mix_right, clip_count, wrap_count,
    // paused_count
    output logic [mvsm_pkg::OUT_DATA_W-1:0]       m_tdata
);
    import mvsm_pkg::*;

    localparam int ADDR_W = $clog2(SAMPLE_DEPTH);
    localparam int CNT_W  = $clog2(VOICES + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PASS  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [11:0]       in_addr;
    logic [31:0]       in_sample;
    logic [12:0]       in_len;
    logic              in_loop;
    logic [8:0]        in_gain;
    logic signed [9:0] in_pan;
    logic [31:0]       in_id;
    logic              in_pflag;

    assign in_addr   = s_tdata[11:0];
    assign in_sample = s_tdata[43:12];
    assign in_len    = s_tdata[56:44];
    assign in_loop   = s_tdata[57];
    assign in_gain   = s_tdata[66:58];
    assign in_pan    = s_tdata[76:67];
    assign in_id     = s_tdata[108:77];
    assign in_pflag  = s_tdata[109];

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [2:0]        req_reg;
    logic [31:0]       id_reg;
    logic              pflag_reg, loop_reg, play_ok_reg;
    logic [8:0]        gain_reg;
    logic signed [9:0] pan_reg;
    logic [11:0]       base_reg;
    logic [12:0]       len_reg;
    logic              hit_reg, hit_next;
    logic [31:0]       aid_reg, aid_next;
    logic [31:0]       next_id_reg, next_id_next;
    logic [3:0]        wraps_reg, wraps_next, pauses_reg, pauses_next;
    logic              m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    term_t             term_reg, term_next;

    logic accept, shift, load_out;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign shift    = (state_reg == ST_PASS);
    assign load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    // voice ring
    voice_t chain [VOICES];
    voice_t head_next;

    for (genvar g = 0; g < VOICES; g++)
    begin : g_cell
        if (g == VOICES - 1)
        begin : g_tail
            mvsm_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .din   (head_next),
                .dout  (chain[g])
            );
        end
        else
        begin : g_body
            mvsm_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .din   (chain[g+1]),
                .dout  (chain[g])
            );
        end
    end

    voice_t            head;
    logic [12:0]       pos_eff;
    logic [16:0]       addr_sum;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [16:0]       wr_addr_ext;
    logic [9:0]        lsub, rsub;
    logic [8:0]        lfac, rfac;
    logic [17:0]       lmul, rmul;
    logic [31:0]       nid;

    assign head = chain[0];

    always_comb
    begin
        head_next    = head;
        hit_next     = hit_reg;
        aid_next     = aid_reg;
        next_id_next = next_id_reg;
        wraps_next   = wraps_reg;
        pauses_next  = pauses_reg;
        term_next    = '0;
        pos_eff      = head.position;

        lsub = UNITY_Q8 - head.pan;
        rsub = UNITY_Q8 + head.pan;
        lfac = (!head.pan[9] && (head.pan != 10'sd0)) ? lsub[8:0] : UNITY_Q8[8:0];
        rfac = head.pan[9] ? rsub[8:0] : UNITY_Q8[8:0];
        lmul = head.gain * lfac;
        rmul = head.gain * rfac;
        term_next.lgain = lmul[16:8];
        term_next.rgain = rmul[16:8];

        nid = (next_id_reg == 32'd0) ? 32'd1 : next_id_reg;

        if (state_reg == ST_PASS)
        begin
            case (req_reg)
                REQ_PLAY:
                begin
                    if (play_ok_reg && !hit_reg && !head.active)
                    begin
                        head_next.active   = 1'b1;
                        head_next.paused   = 1'b0;
                        head_next.looping  = loop_reg;
                        head_next.ident    = nid;
                        head_next.gain     = gain_reg;
                        head_next.pan      = pan_reg;
                        head_next.base     = base_reg;
                        head_next.length   = len_reg;
                        head_next.position = '0;
                        next_id_next       = nid + 32'd1;
                        aid_next           = nid;
                        hit_next           = 1'b1;
                    end
                end
                REQ_STOP, REQ_PAUSE:
                begin
                    if (!hit_reg && head.active && (id_reg != 32'd0) &&
                        (head.ident == id_reg))
                    begin
                        if (req_reg == REQ_STOP)
                        begin
                            head_next.active = 1'b0;
                        end
                        else
                        begin
                            head_next.paused = pflag_reg;
                        end
                        hit_next = 1'b1;
                    end
                end
                REQ_RENDER:
                begin
                    if (head.active && head.paused)
                    begin
                        if (pauses_reg != COUNT_SAT)
                        begin
                            pauses_next = pauses_reg + 4'd1;
                        end
                    end
                    else if (head.active)
                    begin
                        if (head.position >= head.length)
                        begin
                            if (head.looping)
                            begin
                                pos_eff = '0;
                                if (wraps_reg != COUNT_SAT)
                                begin
                                    wraps_next = wraps_reg + 4'd1;
                                end
                                term_next.valid = 1'b1;
                            end
                            else
                            begin
                                head_next.active = 1'b0;
                            end
                        end
                        else
                        begin
                            term_next.valid = 1'b1;
                        end
                        if (term_next.valid)
                        begin
                            head_next.position = pos_eff + 13'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        addr_sum    = 17'(head.base) + 17'(pos_eff);
        rd_addr     = addr_sum[ADDR_W-1:0];
        wr_addr_ext = 17'(in_addr);
        wr_addr     = wr_addr_ext[ADDR_W-1:0];
    end

    logic [31:0] ram_q;

    mvsm_ram #(
        .WIDTH (32),
        .DEPTH (SAMPLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (accept && (s_tuser == REQ_WRITE)),
        .waddr (wr_addr),
        .wdata (in_sample),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    logic signed [15:0] acc_left, acc_right;
    logic [4:0]         clips;

    mvsm_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (accept),
        .term      (term_reg),
        .sample    (ram_q),
        .acc_left  (acc_left),
        .acc_right (acc_right),
        .clips     (clips)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next = '0;
                    if ((s_tuser == REQ_PLAY) || (s_tuser == REQ_STOP) ||
                        (s_tuser == REQ_PAUSE) || (s_tuser == REQ_RENDER))
                    begin
                        state_next = ST_PASS;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_PASS:
            begin
                if (cnt_reg == CNT_W'(VOICES - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (cnt_reg != '0)
                begin
                    state_next = ST_DONE;
                end
                cnt_next = cnt_reg + 1'b1;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    logic status;
    always_comb
    begin
        case (req_reg)
            REQ_WRITE:  status = 1'b1;
            REQ_RENDER: status = 1'b1;
            REQ_PLAY:   status = hit_reg;
            REQ_STOP:   status = hit_reg;
            REQ_PAUSE:  status = hit_reg;
            default:    status = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            req_reg     <= REQ_WRITE;
            hit_reg     <= 1'b0;
            aid_reg     <= '0;
            next_id_reg <= 32'd1;
            wraps_reg   <= '0;
            pauses_reg  <= '0;
            term_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            term_reg    <= term_next;
            next_id_reg <= next_id_next;
            if (accept)
            begin
                req_reg    <= s_tuser;
                hit_reg    <= 1'b0;
                aid_reg    <= '0;
                wraps_reg  <= '0;
                pauses_reg <= '0;
            end
            else
            begin
                hit_reg    <= hit_next;
                aid_reg    <= aid_next;
                wraps_reg  <= wraps_next;
                pauses_reg <= pauses_next;
            end
            if (load_out)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg      <= in_id;
            pflag_reg   <= in_pflag;
            loop_reg    <= in_loop;
            gain_reg    <= in_gain;
            pan_reg     <= in_pan;
            base_reg    <= in_addr;
            len_reg     <= in_len;
            play_ok_reg <= (in_len != 13'd0) && (in_gain <= UNITY_Q8[8:0]) &&
                           (in_pan >= -$signed(UNITY_Q8)) &&
                           (in_pan <= $signed(UNITY_Q8));
        end
        if (load_out)
        begin
            m_data_reg <= {2'b00, pauses_reg, wraps_reg, clips,
                           acc_right, acc_left, aid_reg, status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTH
    a_hit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PASS && hit_reg) |=> hit_reg)
        else $error("request hit lost during ring pass");

    a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PASS) |-> (cnt_reg <= CNT_W'(VOICES - 1)))
        else $error("ring pass ran past the last voice");

    a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && req_reg == REQ_PLAY && hit_reg) |-> (aid_reg != 32'd0))
        else $error("play handed out a zero id");

    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> m_valid_reg)
        else $error("result not presented after load");
`endif
endmodule
`default_nettype wire
